// File: rtl/core/icrt_pkg.sv
// ----------------------------------------------------------------------------
// icrt_pkg: shared types and constants of the retry tracker
// Table geometry, entry and result records, and the function and result codes.
// ----------------------------------------------------------------------------
package icrt_pkg;

  localparam int unsigned TableDepth = 8;
  localparam int unsigned TagWidth   = 32;
  localparam int unsigned ResultCap  = 8;
  localparam int unsigned SlotW      = 3;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned NresW      = $clog2(ResultCap + 1);

  typedef logic [TagWidth-1:0] tag_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [NresW-1:0]    nres_t;
  typedef logic [SlotW-1:0]    slot_t;

  typedef enum logic [1:0] {
    FuncSend = 2'd0,
    FuncAck  = 2'd1,
    FuncTick = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    KindAccepted   = 3'd0,
    KindFull       = 3'd1,
    KindAcked      = 3'd2,
    KindNoMatch    = 3'd3,
    KindRetransmit = 3'd4,
    KindFailed     = 3'd5,
    KindNothing    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    RegMaxChecks   = 2'd0,
    RegMaxRetries  = 2'd1,
    RegLocalAddr   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    tag_t       cmd;
    tag_t       param;
    logic [7:0] rep;
    logic [7:0] checks;
    logic [7:0] peer;
    logic [1:0] port;
    logic       done;
  } entry_t;

  typedef struct packed {
    logic [2:0] kind;
    slot_t      slot;
    tag_t       cmd;
    tag_t       param;
    logic [7:0] rep;
    logic [7:0] peer;
    logic [7:0] src;
    logic [1:0] port;
  } result_t;

endpackage

// File: rtl/core/icrt_table.sv
// ----------------------------------------------------------------------------
// icrt_table: generic RAM
// One write port and one registered read port, width and depth set per instance.
// ----------------------------------------------------------------------------
module icrt_table #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/issued_command_retry_tracker_top.sv
// ----------------------------------------------------------------------------
// issued_command_retry_tracker_top: tracker of sent commands awaiting ack
// Appends sent commands, matches acks, ages entries on ticks and requests
// retransmissions or declares failures, one table entry per cycle.
// ----------------------------------------------------------------------------
// Sequencing: a send beat goes from dispatch straight to flush. An ack or
// tick beat passes through dispatch, compaction of done entries, a scan of
// the live entries and a flush.
// Throughput: one beat at a time; busy stays high until the final result is
// registered, all set by the single table read port stepping one entry a cycle.
// Results cannot be stalled. Reset empties the table and loads register defaults.
module issued_command_retry_tracker_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func_i,
  input  logic [icrt_pkg::TagWidth-1:0] cmd_tag_i,
  input  logic [icrt_pkg::TagWidth-1:0] param_tag_i,
  input  logic                      is_ack_cmd_i,
  input  logic [7:0]                rep_count_i,
  input  logic [7:0]                peer_addr_i,
  input  logic [1:0]                uart_port_i,
  // result channel
  output logic                      result_strobe_o,
  output logic [2:0]                kind_o,
  output logic [2:0]                slot_o,
  output logic [icrt_pkg::TagWidth-1:0] out_cmd_tag_o,
  output logic [icrt_pkg::TagWidth-1:0] out_param_tag_o,
  output logic [7:0]                out_rep_count_o,
  output logic [7:0]                out_peer_addr_o,
  output logic [7:0]                src_addr_o,
  output logic [1:0]                out_uart_port_o,
  output logic                      last_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [2:0] {
    StIdle,
    StDispatch,
    StCompact,
    StScan,
    StFlush
  } state_e;

  typedef struct packed {
    logic [1:0]             func;
    icrt_pkg::tag_t         cmd;
    icrt_pkg::tag_t         param;
    logic                   is_ack;
    logic [7:0]             rep;
    logic [7:0]             peer;
    logic [1:0]             port;
  } req_t;

  // Configuration registers
  logic [7:0] max_checks_q, max_retries_q, local_addr_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // Sequencer state
  state_e            state_q, state_d;
  req_t              req_q, req_d;
  icrt_pkg::cnt_t    cnt_q, cnt_d;     // live table entries
  icrt_pkg::cnt_t    ptr_q, ptr_d;     // read pointer: compaction source, then scan
  icrt_pkg::cnt_t    wr_q, wr_d;       // compaction write pointer
  icrt_pkg::nres_t   nres_q, nres_d;   // results produced on this tick

  // One result is held back so the final one can carry last
  icrt_pkg::result_t pend_q, pend_d;
  logic              pend_v_q, pend_v_d;

  // Output register
  icrt_pkg::result_t out_q, out_d;
  logic              strobe_q, strobe_d;
  logic              last_q, last_d;

  // Table ports
  logic              tbl_we;
  icrt_pkg::idx_t    tbl_waddr;
  icrt_pkg::entry_t  tbl_wdata;
  icrt_pkg::entry_t  rd_entry;

  // Result push / emit helpers
  logic              new_v;
  icrt_pkg::result_t new_res;
  logic              emit;
  icrt_pkg::result_t emit_res;
  logic              emit_last;

  // Address the table with the next pointer so rd_entry holds entry ptr_q
  icrt_table #(
    .Width ($bits(icrt_pkg::entry_t)),
    .Depth (icrt_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (ptr_d[icrt_pkg::IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // --------------------------------------------------------------------------
  // Configuration port: two-phase write, always ready, decode by word address
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      icrt_pkg::RegMaxChecks:  prdata = {24'd0, max_checks_q};
      icrt_pkg::RegMaxRetries: prdata = {24'd0, max_retries_q};
      icrt_pkg::RegLocalAddr:  prdata = {24'd0, local_addr_q};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_checks_q  <= 8'd10;
      max_retries_q <= 8'd3;
      local_addr_q  <= 8'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        icrt_pkg::RegMaxChecks:  max_checks_q  <= pwdata[7:0];
        icrt_pkg::RegMaxRetries: max_retries_q <= pwdata[7:0];
        icrt_pkg::RegLocalAddr:  local_addr_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign busy = (state_q != StIdle);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    wr_d      = wr_q;
    nres_d    = nres_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    tbl_we    = 1'b0;
    tbl_waddr = wr_q[icrt_pkg::IdxW-1:0];
    tbl_wdata = rd_entry;
    new_v     = 1'b0;
    new_res   = '0;
    emit      = 1'b0;
    emit_res  = pend_q;
    emit_last = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          req_d.func   = func_i;
          req_d.cmd    = cmd_tag_i;
          req_d.param  = param_tag_i;
          req_d.is_ack = is_ack_cmd_i;
          req_d.rep    = rep_count_i;
          req_d.peer   = peer_addr_i;
          req_d.port   = uart_port_i;
          state_d      = StDispatch;
        end
      end

      StDispatch: begin
        ptr_d   = '0;
        wr_d    = '0;
        nres_d  = '0;
        state_d = StFlush;
        case (req_q.func)
          icrt_pkg::FuncSend: begin
            if (!req_q.is_ack && req_q.rep == 8'd1) begin
              new_v = 1'b1;
              if (cnt_q < icrt_pkg::cnt_t'(icrt_pkg::TableDepth)) begin
                // Append at the tail of the table
                tbl_we           = 1'b1;
                tbl_waddr        = cnt_q[icrt_pkg::IdxW-1:0];
                tbl_wdata.cmd    = req_q.cmd;
                tbl_wdata.param  = req_q.param;
                tbl_wdata.rep    = req_q.rep;
                tbl_wdata.checks = 8'd0;
                tbl_wdata.peer   = req_q.peer;
                tbl_wdata.port   = req_q.port;
                tbl_wdata.done   = 1'b0;
                cnt_d            = cnt_q + 1'b1;
                new_res.kind     = icrt_pkg::KindAccepted;
                new_res.slot     = icrt_pkg::slot_t'(cnt_q);
              end else begin
                new_res.kind     = icrt_pkg::KindFull;
              end
              new_res.cmd   = req_q.cmd;
              new_res.param = req_q.param;
              new_res.rep   = req_q.rep;
              new_res.peer  = req_q.peer;
              new_res.port  = req_q.port;
            end
          end
          icrt_pkg::FuncAck,
          icrt_pkg::FuncTick: begin
            state_d = StCompact;
          end
          default: ;
        endcase
      end

      StCompact: begin
        // Squeeze out done entries, one source entry per cycle
        if (ptr_q == cnt_q) begin
          cnt_d   = wr_q;
          ptr_d   = '0;
          state_d = StScan;
        end else begin
          if (!rd_entry.done) begin
            tbl_we = 1'b1;
            wr_d   = wr_q + 1'b1;
          end
          ptr_d = ptr_q + 1'b1;
        end
      end

      StScan: begin
        new_res.slot  = icrt_pkg::slot_t'(ptr_q[icrt_pkg::IdxW-1:0]);
        new_res.cmd   = rd_entry.cmd;
        new_res.param = rd_entry.param;
        new_res.rep   = rd_entry.rep;
        new_res.peer  = rd_entry.peer;
        new_res.port  = rd_entry.port;
        tbl_waddr     = ptr_q[icrt_pkg::IdxW-1:0];
        if (req_q.func == icrt_pkg::FuncAck) begin
          if (ptr_q == cnt_q) begin
            // No entry matched: echo the ack fields
            new_v         = 1'b1;
            new_res.kind  = icrt_pkg::KindNoMatch;
            new_res.slot  = '0;
            new_res.cmd   = req_q.cmd;
            new_res.param = req_q.param;
            new_res.rep   = req_q.rep;
            new_res.peer  = req_q.peer;
            new_res.port  = req_q.port;
            state_d       = StFlush;
          end else if (rd_entry.cmd == req_q.cmd && rd_entry.param == req_q.param &&
                       rd_entry.rep == req_q.rep && rd_entry.peer == req_q.peer &&
                       rd_entry.port == req_q.port) begin
            tbl_we         = 1'b1;
            tbl_wdata.done = 1'b1;
            new_v          = 1'b1;
            new_res.kind   = icrt_pkg::KindAcked;
            state_d        = StFlush;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end else begin
          if (ptr_q == cnt_q || nres_q == icrt_pkg::nres_t'(icrt_pkg::ResultCap)) begin
            state_d = StFlush;
          end else if (rd_entry.done) begin
            ptr_d = ptr_q + 1'b1;
          end else if (rd_entry.checks < max_checks_q) begin
            tbl_we           = 1'b1;
            tbl_wdata.checks = rd_entry.checks + 8'd1;
            ptr_d            = ptr_q + 1'b1;
          end else if (rd_entry.rep < max_retries_q) begin
            // Retransmit ends the scan
            tbl_we           = 1'b1;
            tbl_wdata.checks = 8'd0;
            tbl_wdata.rep    = rd_entry.rep + 8'd1;
            new_v            = 1'b1;
            new_res.kind     = icrt_pkg::KindRetransmit;
            new_res.rep      = rd_entry.rep + 8'd1;
            new_res.src      = local_addr_q;
            nres_d           = nres_q + 1'b1;
            state_d          = StFlush;
          end else begin
            tbl_we         = 1'b1;
            tbl_wdata.done = 1'b1;
            new_v          = 1'b1;
            new_res.kind   = icrt_pkg::KindFailed;
            nres_d         = nres_q + 1'b1;
            ptr_d          = ptr_q + 1'b1;
          end
        end
      end

      StFlush: begin
        // Release the held result as the final one, or a nothing result
        emit      = 1'b1;
        emit_last = 1'b1;
        if (!pend_v_q) begin
          emit_res      = '0;
          emit_res.kind = icrt_pkg::KindNothing;
        end
        pend_v_d  = 1'b0;
        state_d   = StIdle;
      end

      default: state_d = StIdle;
    endcase

    // A new result pushes the held one out as a non-final beat
    if (new_v) begin
      if (pend_v_q) begin
        emit      = 1'b1;
        emit_res  = pend_q;
        emit_last = 1'b0;
      end
      pend_d   = new_res;
      pend_v_d = 1'b1;
    end

    strobe_d = emit;
    out_d    = emit ? emit_res  : out_q;
    last_d   = emit ? emit_last : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ptr_q    <= '0;
      wr_q     <= '0;
      nres_q   <= '0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      wr_q     <= wr_d;
      nres_q   <= nres_d;
      pend_v_q <= pend_v_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign result_strobe_o = strobe_q;
  assign kind_o          = out_q.kind;
  assign slot_o          = out_q.slot;
  assign out_cmd_tag_o   = out_q.cmd;
  assign out_param_tag_o = out_q.param;
  assign out_rep_count_o = out_q.rep;
  assign out_peer_addr_o = out_q.peer;
  assign src_addr_o      = out_q.src;
  assign out_uart_port_o = out_q.port;
  assign last_o          = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= icrt_pkg::cnt_t'(icrt_pkg::TableDepth))
    else $error("entry count beyond table depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCompact) |-> (wr_q <= ptr_q))
    else $error("compaction write pointer passed read pointer");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_o) |-> !busy)
    else $error("final result while still busy");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |-> busy)
    else $error("non-final result after the item ended");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_strobe_o)
    else $error("result right after acceptance");

endmodule
